// ===== hw/rtl/edu_pkg.sv =====
package edu_pkg;

    // Sum of squared differences, Q33.24, saturating at 2^56
    localparam int SUM_W = 57;
    localparam logic [SUM_W:0] SUM_CAP = 58'h100_0000_0000_0000;

    // Distance, unsigned Q17.12
    localparam int DIST_W = 29;

    // Square root: one result bit per step
    localparam int ROOT_STEPS = 29;
    localparam int STEP_W = 5;
    localparam int REM_W = 32;

    // Queue of finished sums between accumulator and root unit
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             absent;
    } t_pair;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DONE
    } t_state;

endpackage

// ===== hw/rtl/edu_front.sv =====
module edu_front #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_x_coord,
    input  logic signed [COORD_WIDTH-1:0] i_y_coord,
    input  logic                          i_x_absent,
    input  logic                          i_y_absent,
    input  logic                          i_final_column,
    input  logic [edu_pkg::Q_CNT_W-1:0]   i_q_count,
    output logic                          o_push,
    output edu_pkg::t_pair                o_pair
);
    import edu_pkg::*;

    localparam int MAG_W = COORD_WIDTH + 1;
    localparam int SQ_W  = 2 * COORD_WIDTH + 1;

    logic                    accept;
    logic [Q_CNT_W:0]        pending;
    logic signed [MAG_W-1:0] diff;
    logic [MAG_W-1:0]        mag;
    logic [2*MAG_W-1:0]      product;
    logic                    absent_now;
    logic [SUM_W:0]          total;
    logic [SUM_W-1:0]        sum_next;

    logic                    r_s1_valid;
    logic signed [MAG_W-1:0] r_s1_diff;
    logic                    r_s1_absent;
    logic                    r_s1_last;
    logic                    r_s2_valid;
    logic [SQ_W-1:0]         r_s2_sq;
    logic                    r_s2_absent;
    logic                    r_s2_last;
    logic [SUM_W-1:0]        r_sum;
    logic                    r_saw_absent;

    // Hold input while the queue could not take every pair end in flight
    assign pending = {1'b0, i_q_count}
                   + {{Q_CNT_W{1'b0}}, r_s1_valid & r_s1_last}
                   + {{Q_CNT_W{1'b0}}, r_s2_valid & r_s2_last};
    assign o_stall = (pending >= (Q_CNT_W+1)'(Q_DEPTH));
    assign accept  = i_valid & ~o_stall;

    // Difference of the two coordinates, one bit wider
    assign diff = MAG_W'(i_x_coord) - MAG_W'(i_y_coord);

    // Magnitude and square
    assign mag     = r_s1_diff[MAG_W-1] ? MAG_W'(-r_s1_diff) : MAG_W'(r_s1_diff);
    assign product = {{MAG_W{1'b0}}, mag} * {{MAG_W{1'b0}}, mag};

    // Saturating accumulate
    assign absent_now = r_s2_absent | r_saw_absent;
    assign total      = {1'b0, r_sum} + {{(SUM_W+1-SQ_W){1'b0}}, r_s2_sq};
    always_comb begin
        if (absent_now) begin
            sum_next = r_sum;
        end else if (total >= SUM_CAP) begin
            sum_next = SUM_CAP[SUM_W-1:0];
        end else begin
            sum_next = total[SUM_W-1:0];
        end
    end

    assign o_push        = r_s2_valid & r_s2_last;
    assign o_pair.sum    = sum_next;
    assign o_pair.absent = absent_now;

    // Advance the pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_diff   <= diff;
            r_s1_absent <= i_x_absent | i_y_absent;
            r_s1_last   <= i_final_column;
        end
        r_s2_sq     <= product[SQ_W-1:0];
        r_s2_absent <= r_s1_absent;
        r_s2_last   <= r_s1_last;
    end

    // Running sum; drop it at the end of each pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum        <= '0;
            r_saw_absent <= 1'b0;
        end else if (r_s2_valid) begin
            if (r_s2_last) begin
                r_sum        <= '0;
                r_saw_absent <= 1'b0;
            end else begin
                r_sum        <= sum_next;
                r_saw_absent <= absent_now;
            end
        end
    end

endmodule

// ===== hw/rtl/edu_queue.sv =====
module edu_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  edu_pkg::t_pair              i_pair,
    input  logic                        i_pop,
    output edu_pkg::t_pair              o_head,
    output logic [edu_pkg::Q_CNT_W-1:0] o_count
);
    import edu_pkg::*;

    t_pair              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_count;

    assign o_head  = r_mem[r_rd];
    assign o_count = r_count;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_pair;
        end
    end

endmodule

// ===== hw/rtl/edu_sqrt.sv =====
module edu_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  edu_pkg::t_pair              i_head,
    input  logic [edu_pkg::Q_CNT_W-1:0] i_count,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [edu_pkg::DIST_W-1:0]  o_distance,
    output logic                        o_distance_absent
);
    import edu_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [SUM_W:0]    r_num;
    logic [REM_W-1:0]  r_rem;
    logic [DIST_W-1:0] r_root;
    logic [STEP_W-1:0] r_step;
    logic              r_absent;

    logic              have_pair;
    logic              last_step;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    assign have_pair = (i_count != '0);
    assign last_step = (r_step == STEP_W'(ROOT_STEPS - 1));

    // One root bit: bring down two bits of the radicand, trial subtract
    assign rem_sh = {r_rem[REM_W-3:0], r_num[SUM_W:SUM_W-1]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign take   = (rem_sh >= trial);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (have_pair) begin
                    n_state = i_head.absent ? ST_DONE : ST_CALC;
                end
            end
            ST_CALC: begin
                if (last_step) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_pop   = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            ST_IDLE: o_pop   = have_pair;
            ST_CALC: o_pop   = 1'b0;
            ST_DONE: o_valid = 1'b1;
            default: begin
                o_pop   = 1'b0;
                o_valid = 1'b0;
            end
        endcase
    end

    assign o_distance        = r_root;
    assign o_distance_absent = r_absent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Load a pair and iterate the root
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_num    <= {1'b0, i_head.sum};
                r_rem    <= '0;
                r_root   <= '0;
                r_step   <= '0;
                r_absent <= i_head.absent;
            end
            ST_CALC: begin
                r_num  <= {r_num[SUM_W-2:0], 2'b00};
                r_rem  <= take ? (rem_sh - trial) : rem_sh;
                r_root <= {r_root[DIST_W-2:0], take};
                r_step <= r_step + 1'b1;
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

endmodule

// ===== hw/rtl/euclidean_distance_unit.sv =====
// A result follows its final column through the front pipeline, the queue write, the root load
// and 29 root steps; a missing-coordinate pair goes from the root load straight to done.
// Throughput: one column per cycle into the accumulator while o_stall is low; the root unit
// works on one pair at a time, and a 4-entry queue of sums lets the front run ahead.
// Reset: synchronous, active low; clears pipeline valids, running sum, queue and
// root state. No clearing pass.
module euclidean_distance_unit #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [COORD_WIDTH-1:0]       i_x_coord,
    input  logic signed [COORD_WIDTH-1:0]       i_y_coord,
    input  logic                                i_x_absent,
    input  logic                                i_y_absent,
    input  logic                                i_final_column,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [edu_pkg::DIST_W-1:0]          o_distance,
    output logic                                o_distance_absent
);
    import edu_pkg::*;

    logic               push;
    logic               pop;
    t_pair              pair;
    t_pair              head;
    logic [Q_CNT_W-1:0] q_count;

    edu_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_x_coord      (i_x_coord),
        .i_y_coord      (i_y_coord),
        .i_x_absent     (i_x_absent),
        .i_y_absent     (i_y_absent),
        .i_final_column (i_final_column),
        .i_q_count      (q_count),
        .o_push         (push),
        .o_pair         (pair)
    );

    edu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pair  (pair),
        .i_pop   (pop),
        .o_head  (head),
        .o_count (q_count)
    );

    edu_sqrt u_sqrt (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (head),
        .i_count           (q_count),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_distance        (o_distance),
        .o_distance_absent (o_distance_absent)
    );

endmodule
